@@ hdl/bpfl_pkg.sv @@
`default_nettype none

package bpfl_pkg;

	// Request codes carried in req_type.
	localparam logic [2:0] REQ_GET   = 3'd0;
	localparam logic [2:0] REQ_PEEK  = 3'd1;
	localparam logic [2:0] REQ_PUT   = 3'd2;
	localparam logic [2:0] REQ_COUNT = 3'd3;
	localparam logic [2:0] REQ_CLEAR = 3'd4;

	// List select codes.
	localparam logic [1:0] LIST_FREE = 2'd0;
	localparam logic [1:0] LIST_USED = 2'd1;

	// Status codes.
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_EMPTY   = 2'd1;
	localparam logic [1:0] STAT_BAD_SEL = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
	localparam logic [1:0] CFG_DATA_BYTES = 2'd1;
	localparam logic [1:0] CFG_INFO_BYTES = 2'd2;

	localparam logic [4:0] COUNT_MAX = 5'd31;

	typedef struct packed {
		logic [2:0] req_type;
		logic [1:0] list_sel;
		logic [3:0] node_in;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [3:0]  node_out;
		logic [4:0]  count_out;
		logic [15:0] info_offset;
		logic [19:0] data_offset;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_EXEC,
		ST_PUT2
	} state_t;

endpackage

`default_nettype wire

@@ hdl/bpfl_link_ram.sv @@
`default_nettype none

module bpfl_link_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int WIDTH = 4
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/buffer_pool_free_used_lists.sv @@
// Channel   Handshake                  Payload
// command   start / busy               cmd (req_type, list_sel, node_in)
// result    done (one-cycle strobe)    result (status .. data_offset)
// config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
// A request reads the next-link memory at the selected head when accepted;
// the EXEC state then updates the list registers and writes the memory back.
// A put with a non-empty list adds the PUT2 state for its second link write,
// since the link memory has one write port. The result and done are
// registered at the end of EXEC, with the updated list registers. After reset
// and every node_count write, a sweep rebuilds all MAX_NODES link entries
// with busy high. The receiver cannot stall; config writes are always taken.
`default_nettype none

module buffer_pool_free_used_lists #(
	parameter int MAX_NODES = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire bpfl_pkg::req_t    cmd,
	output logic                   done,
	output bpfl_pkg::rsp_t         result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [15:0]       cfg_data
);

	localparam int IW     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int RST_NC = (MAX_NODES < 16) ? MAX_NODES : 16;
	localparam logic [IW-1:0] LAST_NODE = IW'(MAX_NODES - 1);

	bpfl_pkg::state_t state_q, state_d;

	logic [IW-1:0] free_head_q, free_tail_q, used_head_q, used_tail_q;
	logic [4:0]    free_count_q, used_count_q;
	logic [IW-1:0] free_head_d, free_tail_d, used_head_d, used_tail_d;
	logic [4:0]    free_count_d, used_count_d;

	logic [15:0] data_bytes_q;
	logic [11:0] info_bytes_q;

	logic [IW-1:0] sweep_q, sweep_next;

	bpfl_pkg::req_t req_s1;
	logic [IW-1:0]  node_s1;
	logic [IW-1:0]  put_tail_q;

	logic [IW-1:0] node_mod [16];

	logic          accept;
	logic          cfg_wr, nc_wr;
	logic [4:0]    nc_clamped;

	logic          mem_we;
	logic [IW-1:0] mem_wr_addr, mem_wr_data, mem_rd_addr, link_rd;

	logic          ex_we;
	logic [IW-1:0] ex_wr_addr, ex_wr_data;
	logic          ex_put2;
	bpfl_pkg::rsp_t rsp_d;
	logic [IW-1:0] nout;

	logic [12:0]    info_r4;
	logic [16:0]    data_r4;
	logic [IW+12:0] info_prod;
	logic [IW+16:0] data_prod;

	// Node index modulo the pool size, as a constant table.
	for (genvar k = 0; k < 16; k++) begin : g_mod
		assign node_mod[k] = IW'(k % MAX_NODES);
	end

	assign cfg_ready  = 1'b1;
	assign cfg_wr     = cfg_valid && cfg_ready;
	assign nc_wr      = cfg_wr && (cfg_index == bpfl_pkg::CFG_NODE_COUNT);
	assign nc_clamped = (int'(cfg_data[4:0]) > MAX_NODES) ? 5'(MAX_NODES) : cfg_data[4:0];
	assign accept     = start && !busy;
	assign sweep_next = (sweep_q == LAST_NODE) ? '0 : sweep_q + 1'b1;

	assign mem_rd_addr = cmd.list_sel[0] ? used_head_q : free_head_q;

	bpfl_link_ram #(
		.DEPTH (MAX_NODES),
		.AW    (IW),
		.WIDTH (IW)
	) u_link_ram (
		.clk     (clk),
		.we      (mem_we),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (accept),
		.rd_addr (mem_rd_addr),
		.rd_data (link_rd)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bpfl_pkg::ST_SWEEP: begin
				if (sweep_q == LAST_NODE) begin
					state_d = bpfl_pkg::ST_IDLE;
				end
			end
			bpfl_pkg::ST_IDLE: begin
				if (start) begin
					state_d = bpfl_pkg::ST_EXEC;
				end
			end
			bpfl_pkg::ST_EXEC: begin
				state_d = ex_put2 ? bpfl_pkg::ST_PUT2 : bpfl_pkg::ST_IDLE;
			end
			bpfl_pkg::ST_PUT2: begin
				state_d = bpfl_pkg::ST_IDLE;
			end
			default: begin
				state_d = bpfl_pkg::ST_IDLE;
			end
		endcase
		if (nc_wr) begin
			state_d = bpfl_pkg::ST_SWEEP;
		end
	end

	// State outputs: busy and the link memory write port.
	always_comb begin
		busy        = 1'b1;
		mem_we      = 1'b0;
		mem_wr_addr = sweep_q;
		mem_wr_data = sweep_next;
		unique case (state_q)
			bpfl_pkg::ST_SWEEP: begin
				mem_we = 1'b1;
			end
			bpfl_pkg::ST_IDLE: begin
				busy = 1'b0;
			end
			bpfl_pkg::ST_EXEC: begin
				mem_we      = ex_we;
				mem_wr_addr = ex_wr_addr;
				mem_wr_data = ex_wr_data;
			end
			bpfl_pkg::ST_PUT2: begin
				mem_we      = 1'b1;
				mem_wr_addr = put_tail_q;
				mem_wr_data = node_s1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	// Request execution on the registered command and the link read.
	always_comb begin
		logic [IW-1:0] head_sel, tail_sel;
		logic [4:0]    cnt_sel, cnt_new;
		logic [5:0]    sum;

		head_sel = req_s1.list_sel[0] ? used_head_q : free_head_q;
		tail_sel = req_s1.list_sel[0] ? used_tail_q : free_tail_q;
		cnt_sel  = req_s1.list_sel[0] ? used_count_q : free_count_q;
		cnt_new  = cnt_sel;
		sum      = {1'b0, free_count_q} + {1'b0, used_count_q};

		free_head_d  = free_head_q;
		free_tail_d  = free_tail_q;
		free_count_d = free_count_q;
		used_head_d  = used_head_q;
		used_tail_d  = used_tail_q;
		used_count_d = used_count_q;

		ex_we      = 1'b0;
		ex_wr_addr = free_tail_q;
		ex_wr_data = used_head_q;
		ex_put2    = 1'b0;
		nout       = '0;
		rsp_d      = '0;

		unique case (req_s1.req_type)
			bpfl_pkg::REQ_CLEAR: begin
				// The filled list is spliced onto the free tail in one write.
				if (used_count_q != 5'd0) begin
					if (free_count_q == 5'd0) begin
						free_head_d = used_head_q;
					end else begin
						ex_we = 1'b1;
					end
					free_tail_d  = used_tail_q;
					free_count_d = sum[5] ? bpfl_pkg::COUNT_MAX : sum[4:0];
					used_head_d  = '0;
					used_tail_d  = '0;
					used_count_d = '0;
				end
				rsp_d.count_out = free_count_d;
			end
			bpfl_pkg::REQ_GET, bpfl_pkg::REQ_PEEK, bpfl_pkg::REQ_PUT,
			bpfl_pkg::REQ_COUNT: begin
				if (req_s1.list_sel[1]) begin
					rsp_d.status = bpfl_pkg::STAT_BAD_SEL;
				end else begin
					if (req_s1.req_type == bpfl_pkg::REQ_PUT) begin
						// The new node's link is cleared now; an old tail, if the list
						// was not empty, is linked to it in the PUT2 state.
						ex_we      = 1'b1;
						ex_wr_addr = node_s1;
						ex_wr_data = '0;
						if (cnt_sel == 5'd0) begin
							head_sel = node_s1;
							cnt_new  = 5'd1;
						end else begin
							ex_put2 = 1'b1;
							cnt_new = (cnt_sel == bpfl_pkg::COUNT_MAX) ?
								bpfl_pkg::COUNT_MAX : cnt_sel + 5'd1;
						end
						tail_sel = node_s1;
					end else if ((req_s1.req_type == bpfl_pkg::REQ_GET) ||
						(req_s1.req_type == bpfl_pkg::REQ_PEEK)) begin
						if (cnt_sel == 5'd0) begin
							rsp_d.status = bpfl_pkg::STAT_EMPTY;
						end else begin
							rsp_d.found    = 1'b1;
							nout           = head_sel;
							rsp_d.node_out = 4'(head_sel);
							if (req_s1.req_type == bpfl_pkg::REQ_GET) begin
								if (cnt_sel == 5'd1) begin
									head_sel = '0;
									tail_sel = '0;
									cnt_new  = '0;
								end else begin
									head_sel = link_rd;
									cnt_new  = cnt_sel - 5'd1;
								end
							end
						end
					end
					if (req_s1.list_sel[0]) begin
						used_head_d  = head_sel;
						used_tail_d  = tail_sel;
						used_count_d = cnt_new;
					end else begin
						free_head_d  = head_sel;
						free_tail_d  = tail_sel;
						free_count_d = cnt_new;
					end
					rsp_d.count_out = (rsp_d.status == bpfl_pkg::STAT_EMPTY) ? 5'd0 : cnt_new;
				end
			end
			default: begin
				rsp_d = '0;
			end
		endcase

		rsp_d.info_offset = rsp_d.found ? 16'(info_prod) : 16'd0;
		rsp_d.data_offset = rsp_d.found ? 20'(data_prod) : 20'd0;
	end

	assign info_r4   = ({1'b0, info_bytes_q} + 13'd3) & ~13'd3;
	assign data_r4   = ({1'b0, data_bytes_q} + 17'd3) & ~17'd3;
	assign info_prod = {13'd0, nout} * {{IW{1'b0}}, info_r4};
	assign data_prod = {17'd0, nout} * {{IW{1'b0}}, data_r4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= bpfl_pkg::ST_SWEEP;
			sweep_q      <= '0;
			free_head_q  <= '0;
			free_tail_q  <= IW'(RST_NC - 1);
			free_count_q <= 5'(RST_NC);
			used_head_q  <= '0;
			used_tail_q  <= '0;
			used_count_q <= '0;
			data_bytes_q <= '0;
			info_bytes_q <= '0;
			done         <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= (state_q == bpfl_pkg::ST_EXEC);
			if (nc_wr) begin
				// Rebuild: free list holds every node in order, filled list empty.
				sweep_q      <= '0;
				free_head_q  <= '0;
				free_tail_q  <= (nc_clamped == 5'd0) ? '0 : IW'(nc_clamped - 5'd1);
				free_count_q <= nc_clamped;
				used_head_q  <= '0;
				used_tail_q  <= '0;
				used_count_q <= '0;
			end else begin
				if (state_q == bpfl_pkg::ST_SWEEP) begin
					sweep_q <= sweep_next;
				end
				if (state_q == bpfl_pkg::ST_EXEC) begin
					free_head_q  <= free_head_d;
					free_tail_q  <= free_tail_d;
					free_count_q <= free_count_d;
					used_head_q  <= used_head_d;
					used_tail_q  <= used_tail_d;
					used_count_q <= used_count_d;
				end
			end
			if (cfg_wr && (cfg_index == bpfl_pkg::CFG_DATA_BYTES)) begin
				data_bytes_q <= cfg_data;
			end
			if (cfg_wr && (cfg_index == bpfl_pkg::CFG_INFO_BYTES)) begin
				info_bytes_q <= cfg_data[11:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= cmd;
			node_s1 <= node_mod[cmd.node_in];
		end
		if (state_q == bpfl_pkg::ST_EXEC) begin
			put_tail_q <= req_s1.list_sel[0] ? used_tail_q : free_tail_q;
			result     <= rsp_d;
		end
	end

endmodule

`default_nettype wire

@@ tb/sv/tb_buffer_pool_free_used_lists.sv @@
`timescale 1ns / 1ps

module tb_buffer_pool_free_used_lists;

	localparam int POOL_NODES  = 16;
	localparam int STALL_LIMIT = 500;
	localparam int PHASE_OPS   = 200;
	localparam int PHASES      = 7;

	localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;
	localparam logic [1:0] LIST_BAD_FIRST   = 2'd2;
	localparam logic [1:0] LIST_BAD_LAST    = 2'd3;

	typedef struct packed {
		bpfl_pkg::req_t op;
		logic           typed;
		bpfl_pkg::rsp_t want;
	} dir_row_t;

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	bpfl_pkg::req_t cmd;
	logic           done;
	bpfl_pkg::rsp_t result;
	logic           cfg_valid;
	logic           cfg_ready;
	logic [1:0]     cfg_index;
	logic [15:0]    cfg_data;

	// Shadow copy of the pool: index 0 is the free list, index 1 the filled list.
	logic [3:0]  link_mem [POOL_NODES];
	logic [3:0]  list_head [2];
	logic [3:0]  list_tail [2];
	logic [4:0]  list_count [2];
	logic [4:0]  pool_size;
	logic [15:0] data_size;
	logic [11:0] info_size;

	bpfl_pkg::rsp_t expected_rsp_q [$];
	logic [3:0]     held_nodes [$];
	dir_row_t       dir_rows [$];
	bpfl_pkg::rsp_t exp_rsp;
	bpfl_pkg::rsp_t pred_rsp;
	logic           row_typed;
	bpfl_pkg::rsp_t row_rsp;
	int             errors;
	int             stall_cycles;
	int             burst_left;

	buffer_pool_free_used_lists #(
		.MAX_NODES(POOL_NODES)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void rebuild_pool();
		for (int i = 0; i < POOL_NODES; i++) begin
			link_mem[i] = 4'((i + 1) % POOL_NODES);
		end
		list_head[0]  = '0;
		list_tail[0]  = (pool_size != 0) ? 4'(pool_size - 5'd1) : 4'd0;
		list_count[0] = pool_size;
		list_head[1]  = '0;
		list_tail[1]  = '0;
		list_count[1] = '0;
	endfunction

	function automatic bpfl_pkg::rsp_t predict_pool_op(input bpfl_pkg::req_t op);
		bpfl_pkg::rsp_t r;
		int             s;
		logic [3:0]     n;
		logic [5:0]     sum;
		logic [31:0]    info_step;
		logic [31:0]    data_step;
		r = '0;
		if (op.req_type == bpfl_pkg::REQ_CLEAR) begin
			if (list_count[1] != 0) begin
				if (list_count[0] == 0) begin
					list_head[0] = list_head[1];
				end else begin
					link_mem[list_tail[0]] = list_head[1];
				end
				list_tail[0]  = list_tail[1];
				sum           = {1'b0, list_count[0]} + {1'b0, list_count[1]};
				list_count[0] = (sum > {1'b0, bpfl_pkg::COUNT_MAX}) ? bpfl_pkg::COUNT_MAX
					: sum[4:0];
				list_head[1]  = '0;
				list_tail[1]  = '0;
				list_count[1] = '0;
			end
			r.count_out = list_count[0];
			return r;
		end
		if (op.req_type > bpfl_pkg::REQ_CLEAR) return r;
		if (op.list_sel > bpfl_pkg::LIST_USED) begin
			r.status = bpfl_pkg::STAT_BAD_SEL;
			return r;
		end
		s = int'(op.list_sel[0]);
		case (op.req_type)
			bpfl_pkg::REQ_GET, bpfl_pkg::REQ_PEEK: begin
				if (list_count[s] == 0) begin
					r.status = bpfl_pkg::STAT_EMPTY;
				end else begin
					n          = list_head[s];
					r.found    = 1'b1;
					r.node_out = n;
					if (op.req_type == bpfl_pkg::REQ_GET) begin
						if (list_count[s] == 1) begin
							list_head[s]  = '0;
							list_tail[s]  = '0;
							list_count[s] = '0;
						end else begin
							list_head[s]  = link_mem[n];
							list_count[s] = list_count[s] - 5'd1;
						end
					end
					r.count_out   = list_count[s];
					info_step     = (32'(info_size) + 32'd3) & ~32'd3;
					data_step     = (32'(data_size) + 32'd3) & ~32'd3;
					r.info_offset = 16'(32'(n) * info_step);
					r.data_offset = 20'(32'(n) * data_step);
				end
			end
			bpfl_pkg::REQ_PUT: begin
				link_mem[op.node_in] = '0;
				if (list_count[s] == 0) begin
					list_head[s]  = op.node_in;
					list_tail[s]  = op.node_in;
					list_count[s] = 5'd1;
				end else begin
					link_mem[list_tail[s]] = op.node_in;
					list_tail[s]           = op.node_in;
					list_count[s] = (list_count[s] >= bpfl_pkg::COUNT_MAX) ? bpfl_pkg::COUNT_MAX
						: list_count[s] + 5'd1;
				end
				r.count_out = list_count[s];
			end
			default: begin
				r.count_out = list_count[s];
			end
		endcase
		return r;
	endfunction

	function automatic bpfl_pkg::rsp_t plain_rsp(input logic [1:0] status, input logic found,
		input logic [3:0] node, input logic [4:0] count);
		bpfl_pkg::rsp_t r;
		r           = '0;
		r.status    = status;
		r.found     = found;
		r.node_out  = node;
		r.count_out = count;
		return r;
	endfunction

	function automatic void add_row(input logic [2:0] req, input logic [1:0] sel,
		input logic [3:0] node, input logic typed, input bpfl_pkg::rsp_t want);
		dir_row_t row;
		row.op.req_type = req;
		row.op.list_sel = sel;
		row.op.node_in  = node;
		row.typed       = typed;
		row.want        = want;
		dir_rows.push_back(row);
	endfunction

	// Mostly recycles nodes between the two lists; the rest is noise.
	function automatic bpfl_pkg::req_t random_op();
		bpfl_pkg::req_t op;
		int             pick;
		pick        = $urandom_range(0, 99);
		op.req_type = bpfl_pkg::REQ_GET;
		op.list_sel = 2'($urandom_range(0, 1));
		op.node_in  = 4'($urandom_range(0, 15));
		if (pick < 30) begin
			op.req_type = bpfl_pkg::REQ_GET;
		end else if (pick < 55) begin
			op.req_type = bpfl_pkg::REQ_PUT;
			if (held_nodes.size() != 0) begin
				op.node_in  = held_nodes.pop_front();
				op.list_sel = ($urandom_range(0, 9) < 7) ? bpfl_pkg::LIST_USED
					: bpfl_pkg::LIST_FREE;
			end
		end else if (pick < 65) begin
			op.req_type = bpfl_pkg::REQ_PEEK;
		end else if (pick < 73) begin
			op.req_type = bpfl_pkg::REQ_COUNT;
		end else if (pick < 80) begin
			op.req_type = bpfl_pkg::REQ_CLEAR;
			op.list_sel = 2'($urandom_range(0, 3));
		end else if (pick < 87) begin
			op.req_type = bpfl_pkg::REQ_PUT;
		end else if (pick < 94) begin
			op.req_type = 3'($urandom_range(bpfl_pkg::REQ_GET, bpfl_pkg::REQ_COUNT));
			op.list_sel = 2'($urandom_range(LIST_BAD_FIRST, LIST_BAD_LAST));
		end else begin
			op.req_type = 3'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
			op.list_sel = 2'($urandom_range(0, 3));
		end
		return op;
	endfunction

	task automatic send_op(input bpfl_pkg::req_t op, input logic typed,
		input bpfl_pkg::rsp_t want);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			repeat (gap) @(negedge clk) start <= 1'b0;
		end
		burst_left--;
		@(negedge clk);
		start     <= 1'b1;
		cmd       <= op;
		row_typed = typed;
		row_rsp   = want;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	task automatic wait_idle();
		@(negedge clk) start <= 1'b0;
		while (expected_rsp_q.size() != 0 || busy !== 1'b0) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			bpfl_pkg::CFG_NODE_COUNT: begin
				pool_size = (val[4:0] > POOL_NODES) ? 5'(POOL_NODES) : val[4:0];
				rebuild_pool();
				held_nodes.delete();
			end
			bpfl_pkg::CFG_DATA_BYTES: begin
				data_size = val;
			end
			bpfl_pkg::CFG_INFO_BYTES: begin
				info_size = val[11:0];
			end
			default: begin
			end
		endcase
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	// Results are checked and transactions predicted at the same edge; a result
	// never belongs to a transaction accepted at that edge.
	always @(posedge clk) begin
		if (done === 1'b1) begin
			if (expected_rsp_q.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, actual %h", $time, result);
			end else begin
				exp_rsp = expected_rsp_q.pop_front();
				check_field("status", 32'(exp_rsp.status), 32'(result.status));
				check_field("found", 32'(exp_rsp.found), 32'(result.found));
				check_field("node_out", 32'(exp_rsp.node_out), 32'(result.node_out));
				check_field("count_out", 32'(exp_rsp.count_out), 32'(result.count_out));
				check_field("info_offset", 32'(exp_rsp.info_offset),
					32'(result.info_offset));
				check_field("data_offset", 32'(exp_rsp.data_offset),
					32'(result.data_offset));
			end
		end
		if (arst_n === 1'b1 && start === 1'b1 && busy === 1'b0) begin
			pred_rsp = predict_pool_op(cmd);
			expected_rsp_q.push_back(row_typed ? row_rsp : pred_rsp);
			if (cmd.req_type == bpfl_pkg::REQ_GET && pred_rsp.found) begin
				held_nodes.push_back(pred_rsp.node_out);
			end
		end
	end

	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1
			|| (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_buffer_pool_free_used_lists: errors");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int             p;
		int             k;
		int             flood_len;
		logic [3:0]     flood_node;
		logic [1:0]     flood_list;
		bpfl_pkg::req_t op;
		int             pool_plan [PHASES];
		int             data_plan [PHASES];
		int             info_plan [PHASES];

		errors       = 0;
		stall_cycles = 0;
		burst_left   = 0;
		row_typed    = 1'b0;
		row_rsp      = '0;
		start        = 1'b0;
		cmd          = '0;
		cfg_valid    = 1'b0;
		cfg_index    = bpfl_pkg::CFG_NODE_COUNT;
		cfg_data     = '0;
		arst_n       = 1'b0;
		pool_size    = 5'(POOL_NODES);
		data_size    = '0;
		info_size    = '0;
		rebuild_pool();

		pool_plan = '{16, 0, 1, 31, 17, 3, 8};
		data_plan = '{65535, 0, 1, 2, 65533, 0, 0};
		info_plan = '{4095, 0, 3, 1, 4094, 0, 0};
		pool_plan[PHASES - 1] = $urandom_range(2, 16);
		data_plan[PHASES - 2] = $urandom_range(0, 65535);
		data_plan[PHASES - 1] = $urandom_range(0, 65535);
		info_plan[PHASES - 2] = $urandom_range(0, 4095);
		info_plan[PHASES - 1] = $urandom_range(0, 4095);

		// Reset configuration: sixteen nodes, zero-sized areas, so offsets are zero.
		add_row(bpfl_pkg::REQ_COUNT, bpfl_pkg::LIST_FREE, 4'd0, 1'b1,
			plain_rsp(bpfl_pkg::STAT_OK, 1'b0, 4'd0, 5'd16));
		add_row(bpfl_pkg::REQ_COUNT, bpfl_pkg::LIST_USED, 4'd0, 1'b1,
			plain_rsp(bpfl_pkg::STAT_OK, 1'b0, 4'd0, 5'd0));
		add_row(bpfl_pkg::REQ_PEEK, bpfl_pkg::LIST_USED, 4'd0, 1'b1,
			plain_rsp(bpfl_pkg::STAT_EMPTY, 1'b0, 4'd0, 5'd0));
		add_row(bpfl_pkg::REQ_GET, bpfl_pkg::LIST_USED, 4'd0, 1'b1,
			plain_rsp(bpfl_pkg::STAT_EMPTY, 1'b0, 4'd0, 5'd0));
		add_row(bpfl_pkg::REQ_GET, LIST_BAD_FIRST, 4'd0, 1'b1,
			plain_rsp(bpfl_pkg::STAT_BAD_SEL, 1'b0, 4'd0, 5'd0));
		add_row(bpfl_pkg::REQ_PUT, LIST_BAD_LAST, 4'd15, 1'b1,
			plain_rsp(bpfl_pkg::STAT_BAD_SEL, 1'b0, 4'd0, 5'd0));
		add_row(REQ_UNUSED_FIRST, bpfl_pkg::LIST_FREE, 4'd0, 1'b1, '0);
		add_row(REQ_UNUSED_LAST, LIST_BAD_LAST, 4'd15, 1'b1, '0);
		add_row(bpfl_pkg::REQ_PEEK, bpfl_pkg::LIST_FREE, 4'd0, 1'b1,
			plain_rsp(bpfl_pkg::STAT_OK, 1'b1, 4'd0, 5'd16));
		add_row(bpfl_pkg::REQ_GET, bpfl_pkg::LIST_FREE, 4'd0, 1'b1,
			plain_rsp(bpfl_pkg::STAT_OK, 1'b1, 4'd0, 5'd15));
		add_row(bpfl_pkg::REQ_GET, bpfl_pkg::LIST_FREE, 4'd0, 1'b1,
			plain_rsp(bpfl_pkg::STAT_OK, 1'b1, 4'd1, 5'd14));
		add_row(bpfl_pkg::REQ_PUT, bpfl_pkg::LIST_USED, 4'd0, 1'b1,
			plain_rsp(bpfl_pkg::STAT_OK, 1'b0, 4'd0, 5'd1));
		add_row(bpfl_pkg::REQ_PUT, bpfl_pkg::LIST_USED, 4'd1, 1'b1,
			plain_rsp(bpfl_pkg::STAT_OK, 1'b0, 4'd0, 5'd2));
		add_row(bpfl_pkg::REQ_PEEK, bpfl_pkg::LIST_USED, 4'd0, 1'b1,
			plain_rsp(bpfl_pkg::STAT_OK, 1'b1, 4'd0, 5'd2));
		add_row(bpfl_pkg::REQ_GET, bpfl_pkg::LIST_USED, 4'd0, 1'b1,
			plain_rsp(bpfl_pkg::STAT_OK, 1'b1, 4'd0, 5'd1));
		// Clear ignores the list select, even an invalid one.
		add_row(bpfl_pkg::REQ_CLEAR, LIST_BAD_LAST, 4'd0, 1'b1,
			plain_rsp(bpfl_pkg::STAT_OK, 1'b0, 4'd0, 5'd15));
		add_row(bpfl_pkg::REQ_COUNT, bpfl_pkg::LIST_USED, 4'd0, 1'b1,
			plain_rsp(bpfl_pkg::STAT_OK, 1'b0, 4'd0, 5'd0));
		add_row(bpfl_pkg::REQ_PUT, bpfl_pkg::LIST_FREE, 4'd0, 1'b1,
			plain_rsp(bpfl_pkg::STAT_OK, 1'b0, 4'd0, 5'd16));
		add_row(bpfl_pkg::REQ_CLEAR, bpfl_pkg::LIST_FREE, 4'd0, 1'b1,
			plain_rsp(bpfl_pkg::STAT_OK, 1'b0, 4'd0, 5'd16));
		add_row(bpfl_pkg::REQ_GET, bpfl_pkg::LIST_FREE, 4'd0, 1'b0, '0);
		add_row(bpfl_pkg::REQ_PUT, bpfl_pkg::LIST_USED, 4'd2, 1'b0, '0);
		add_row(bpfl_pkg::REQ_GET, bpfl_pkg::LIST_USED, 4'd0, 1'b0, '0);
		add_row(bpfl_pkg::REQ_PEEK, bpfl_pkg::LIST_FREE, 4'd0, 1'b0, '0);
		add_row(bpfl_pkg::REQ_COUNT, LIST_BAD_FIRST, 4'd0, 1'b1,
			plain_rsp(bpfl_pkg::STAT_BAD_SEL, 1'b0, 4'd0, 5'd0));

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			send_op(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].want);
		end

		for (p = 0; p < PHASES; p++) begin
			wait_idle();
			cfg_write(bpfl_pkg::CFG_DATA_BYTES, 16'(data_plan[p]));
			cfg_write(bpfl_pkg::CFG_INFO_BYTES, 16'(info_plan[p]));
			cfg_write(bpfl_pkg::CFG_NODE_COUNT, 16'(pool_plan[p]));
			k = 0;
			while (k < PHASE_OPS) begin
				if ($urandom_range(0, 59) == 0) begin
					// Repeated puts of one node drive a count toward saturation.
					flood_len  = $urandom_range(16, 34);
					flood_node = 4'($urandom_range(0, 15));
					flood_list = ($urandom_range(0, 1) == 0) ? bpfl_pkg::LIST_FREE
						: bpfl_pkg::LIST_USED;
					op.req_type = bpfl_pkg::REQ_PUT;
					op.list_sel = flood_list;
					op.node_in  = flood_node;
					repeat (flood_len) send_op(op, 1'b0, '0);
					k += flood_len;
				end else begin
					send_op(random_op(), 1'b0, '0);
					k++;
				end
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (errors == 0 && expected_rsp_q.size() == 0) begin
			$display("tb_buffer_pool_free_used_lists: clean");
		end else begin
			$display("tb_buffer_pool_free_used_lists: errors");
		end
		$finish;
	end

endmodule
